// ----- rtl/wppd_pkg.sv -----
package wppd_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 24;

  // configuration port
  localparam int WL_BITS        = 24;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 24;

  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LENGTH = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COMPLEX_MODE  = 1'd1;

  // peak queue between front and back
  localparam int Q_DEPTH = 4;

  // result format, 1/256 dB
  localparam int DB_BITS  = 17;
  localparam int FLOOR_DB = -51200;
  localparam int CEIL_DB  = 1024;

  // 256*10*log10(2) in Q16
  localparam int DB_SCALE_Q16 = 50504453;

  // round(65536*log2(1+k/16)), k = 0..16
  localparam logic [16:0] LOG_FRAC_TAB [17] = '{
    17'd0,     17'd5732,  17'd11136, 17'd16248, 17'd21098, 17'd25711,
    17'd30109, 17'd34312, 17'd38336, 17'd42196, 17'd45904, 17'd49472,
    17'd52911, 17'd56228, 17'd59434, 17'd62534, 17'd65536
  };

endpackage

// ----- rtl/wppd_in_if.sv -----
interface wppd_in_if #(
  parameter int SAMPLE_BITS = wppd_pkg::SAMPLE_BITS
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] i_sample;
  logic signed [SAMPLE_BITS-1:0] q_sample;

  modport source (output valid, output i_sample, output q_sample, input ready);
  modport sink (input valid, input i_sample, input q_sample, output ready);
endinterface

// ----- rtl/wppd_out_if.sv -----
interface wppd_out_if ();
  logic                                valid;
  logic                                ready;
  logic signed [wppd_pkg::DB_BITS-1:0] peak_db;
  logic                                at_floor;

  modport source (output valid, output peak_db, output at_floor, input ready);
  modport sink (input valid, input peak_db, input at_floor, output ready);
endinterface

// ----- rtl/wppd_front.sv -----
module wppd_front #(
  parameter int SAMPLE_BITS = wppd_pkg::SAMPLE_BITS,
  parameter int COUNT_BITS  = wppd_pkg::COUNT_BITS
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [wppd_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [wppd_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  wppd_in_if.sink                                 samples,
  output logic                                    push,
  output logic [2*SAMPLE_BITS-1:0]                push_peak,
  input  logic                                    full
);

  localparam int PW   = 2 * SAMPLE_BITS;
  localparam int WLW  = wppd_pkg::WL_BITS;
  localparam int CMPW = (COUNT_BITS + 1 > WLW) ? COUNT_BITS + 1 : WLW;

  logic [WLW-1:0]         window_length;
  logic                   complex_mode;
  logic [COUNT_BITS-1:0]  frame_count;
  logic [COUNT_BITS-1:0]  frame_count_next;
  logic                   s1_valid;
  logic                   s1_close;
  logic [SAMPLE_BITS-1:0] s1_mag_i;
  logic [SAMPLE_BITS-1:0] s1_mag_q;
  logic                   s2_valid;
  logic                   s2_close;
  logic [PW-1:0]          s2_sq_i;
  logic [PW-1:0]          s2_sq_q;
  logic [PW-1:0]          peak_power;
  logic [PW-1:0]          peak_next;
  logic [PW-1:0]          power;
  logic [CMPW-1:0]        count_inc;
  logic                   close_now;
  logic                   accept;
  logic                   stall;

  function automatic logic [SAMPLE_BITS-1:0] magnitude(input logic [SAMPLE_BITS-1:0] v);
    return v[SAMPLE_BITS-1] ? (~v + SAMPLE_BITS'(1)) : v;
  endfunction

  // front stalls only when a window closes into a full queue
  assign stall         = s2_valid & s2_close & full;
  assign samples.ready = ~stall;
  assign accept        = samples.valid & samples.ready;

  // effective window is min(window_length, 2^COUNT_BITS), zero acts as one
  assign count_inc = CMPW'(frame_count) + CMPW'(1);
  assign close_now = (window_length == '0) || (count_inc >= CMPW'(window_length)) ||
                     (&frame_count);
  assign frame_count_next = close_now ? '0 : frame_count + COUNT_BITS'(1);

  assign power     = s2_sq_i + s2_sq_q;
  assign peak_next = (power > peak_power) ? power : peak_power;
  assign push      = s2_valid & s2_close & ~full;
  assign push_peak = peak_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WLW'(1);
      complex_mode  <= 1'b1;
      frame_count   <= '0;
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      peak_power    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          wppd_pkg::REG_WINDOW_LENGTH: window_length <= cfg_data[WLW-1:0];
          wppd_pkg::REG_COMPLEX_MODE:  complex_mode  <= cfg_data[0];
        endcase
      end
      if (!stall) begin
        s1_valid <= accept;
        s2_valid <= s1_valid;
      end
      if (accept) begin
        frame_count <= frame_count_next;
      end
      if (s2_valid && !stall) begin
        peak_power <= s2_close ? '0 : peak_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mag_i <= magnitude(samples.i_sample);
      s1_mag_q <= complex_mode ? magnitude(samples.q_sample) : '0;
      s1_close <= close_now;
    end
    if (!stall) begin
      s2_sq_i  <= PW'(s1_mag_i) * PW'(s1_mag_i);
      s2_sq_q  <= PW'(s1_mag_q) * PW'(s1_mag_q);
      s2_close <= s1_close;
    end
  end

endmodule

// ----- rtl/wppd_queue.sv -----
module wppd_queue #(
  parameter int WIDTH = 2 * wppd_pkg::SAMPLE_BITS,
  parameter int DEPTH = wppd_pkg::Q_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] entries [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] ptr);
    return (ptr == AW'(DEPTH - 1)) ? '0 : ptr + AW'(1);
  endfunction

  assign full     = (count == (AW + 1)'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + (AW + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (AW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("peak queue overflow");
  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("peak queue underflow");
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
      count <= (AW + 1)'(DEPTH))
    else $error("peak queue count out of range");

endmodule

// ----- rtl/wppd_back.sv -----
module wppd_back #(
  parameter int SAMPLE_BITS = wppd_pkg::SAMPLE_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  output logic                     pop,
  input  logic [2*SAMPLE_BITS-1:0] peak,
  input  logic                     empty,
  wppd_out_if.source               results
);

  localparam int PW         = 2 * SAMPLE_BITS;
  localparam int LW         = $clog2(PW);
  localparam int NW         = PW + 16;
  localparam int XW         = LW + 17;
  localparam int PRW        = XW + 27;
  localparam int OFFSET_INT = (PW - 2) * 65536;
  localparam int DBW        = wppd_pkg::DB_BITS;

  localparam logic [XW-1:0]         OFFSET = XW'(OFFSET_INT);
  localparam logic signed [PRW-1:0] SCALE  = PRW'(wppd_pkg::DB_SCALE_Q16);
  localparam logic signed [PRW-1:0] HALF   = PRW'(33'h0_8000_0000);

  logic adv;

  logic                 b1_valid;
  logic                 b1_zero;
  logic [LW-1:0]        b1_e;
  logic [PW-1:0]        b1_p;
  logic                 b2_valid;
  logic                 b2_zero;
  logic [LW-1:0]        b2_e;
  logic [15:0]          b2_f;
  logic                 b3_valid;
  logic                 b3_zero;
  logic [LW-1:0]        b3_e;
  logic [15:0]          b3_lo;
  logic [24:0]          b3_d;
  logic                 b4_valid;
  logic                 b4_zero;
  logic signed [XW-1:0] b4_x;
  logic                 b5_valid;
  logic                 b5_zero;
  logic signed [PRW-1:0] b5_prod;
  logic                 out_valid;
  logic signed [DBW-1:0] out_db;
  logic                 out_floor;

  logic [LW-1:0]         lod;
  logic [NW-1:0]         norm;
  logic [4:0]            tab_idx;
  logic [16:0]           tab_lo;
  logic [16:0]           tab_hi;
  logic [12:0]           tab_diff;
  logic [XW-1:0]         log_pos;
  logic signed [PRW-1:0] rnd;
  logic signed [31:0]    db_raw;
  logic signed [31:0]    db_clamped;

  assign adv = ~out_valid | results.ready;
  assign pop = adv & ~empty;

  // leading one of the queue head
  always_comb begin
    lod = '0;
    for (int k = 0; k < PW; k++) begin
      if (peak[k]) begin
        lod = LW'(k);
      end
    end
  end

  // normalize so the leading one sits at the top, take the 16 bits below it
  assign norm = {b1_p, 16'b0} << (LW'(PW - 1) - b1_e);

  assign tab_idx  = {1'b0, b2_f[15:12]};
  assign tab_lo   = wppd_pkg::LOG_FRAC_TAB[tab_idx];
  assign tab_hi   = wppd_pkg::LOG_FRAC_TAB[tab_idx + 5'd1];
  assign tab_diff = 13'(tab_hi - tab_lo);

  assign log_pos = XW'({b3_e, 16'b0}) + XW'(b3_lo) + XW'(b3_d[24:12]);

  // floor((x*scale + 2^31) / 2^32), then clamp
  assign rnd    = b5_prod + HALF;
  assign db_raw = 32'($signed(rnd[PRW-1:32]));

  always_comb begin
    priority if (b5_zero) begin
      db_clamped = wppd_pkg::FLOOR_DB;
    end else if (db_raw < wppd_pkg::FLOOR_DB) begin
      db_clamped = wppd_pkg::FLOOR_DB;
    end else if (db_raw > wppd_pkg::CEIL_DB) begin
      db_clamped = wppd_pkg::CEIL_DB;
    end else begin
      db_clamped = db_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid  <= 1'b0;
      b2_valid  <= 1'b0;
      b3_valid  <= 1'b0;
      b4_valid  <= 1'b0;
      b5_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      b1_valid  <= pop;
      b2_valid  <= b1_valid;
      b3_valid  <= b2_valid;
      b4_valid  <= b3_valid;
      b5_valid  <= b4_valid;
      out_valid <= b5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_p      <= peak;
      b1_e      <= lod;
      b1_zero   <= (peak == '0);
      b2_f      <= norm[NW-2 -: 16];
      b2_e      <= b1_e;
      b2_zero   <= b1_zero;
      b3_lo     <= tab_lo[15:0];
      b3_d      <= 25'(tab_diff) * 25'(b2_f[11:0]);
      b3_e      <= b2_e;
      b3_zero   <= b2_zero;
      b4_x      <= $signed(log_pos - OFFSET);
      b4_zero   <= b3_zero;
      b5_prod   <= PRW'(b4_x) * SCALE;
      b5_zero   <= b4_zero;
      out_db    <= DBW'(db_clamped);
      out_floor <= b5_zero;
    end
  end

  assign results.valid    = out_valid;
  assign results.peak_db  = out_db;
  assign results.at_floor = out_floor;

  a_lod_hits_one: assert property (@(posedge clk) disable iff (rst)
      b1_valid && !b1_zero |-> b1_p[b1_e])
    else $error("leading one detect missed");
  a_floor_value: assert property (@(posedge clk) disable iff (rst)
      out_valid && out_floor |-> out_db == DBW'(wppd_pkg::FLOOR_DB))
    else $error("floor flag without floor value");

endmodule

// ----- rtl/windowed_peak_power_db.sv -----
// the last frame of a window reaches the output register through front stages s1, s2,
// the peak queue and back stages b1 to b5
// throughput: one frame per clock; the input stalls only while a closing window finds
// the 4-entry peak queue full, and the queue fills only under output backpressure
// reset (rst, synchronous): window_length 1, complex_mode 1, frame count and peak cleared
module windowed_peak_power_db #(
  parameter int SAMPLE_BITS = wppd_pkg::SAMPLE_BITS,
  parameter int COUNT_BITS  = wppd_pkg::COUNT_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [wppd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [wppd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  wppd_in_if.sink                             samples,
  wppd_out_if.source                          results
);

  // frame power is at most 2^(2*SAMPLE_BITS-1), so the peak fits in 2*SAMPLE_BITS bits
  localparam int PW = 2 * SAMPLE_BITS;

  // front to queue: one push per closed window
  logic          push;
  logic [PW-1:0] push_peak;
  logic          full;

  // queue to back
  logic          pop;
  logic [PW-1:0] head_peak;
  logic          empty;

  // front: config registers, sample magnitude, squares, running max and window counter
  // one frame per cycle unless a full queue stalls it, through two register stages, then the max update
  wppd_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (samples),
    .push      (push),
    .push_peak (push_peak),
    .full      (full)
  );

  // short queue of window peaks, lets the front keep running while a result waits
  wppd_queue #(
    .WIDTH (PW),
    .DEPTH (wppd_pkg::Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_peak),
    .full      (full),
    .pop       (pop),
    .pop_data  (head_peak),
    .empty     (empty)
  );

  // back: leading-one detect, normalize, log2 table with interpolation, scale to dB,
  // round and clamp; six stages ending in the output register
  wppd_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .pop     (pop),
    .peak    (head_peak),
    .empty   (empty),
    .results (results)
  );

endmodule
